// ===== src/trs_pkg.sv =====
// Package for the TRS model matrix builder: shared types, Q-format constants
// and the CORDIC arctangent table. No dependencies.
package trs_pkg;

   // number of arctangent entries available to the CORDIC lanes
   localparam int unsigned AtanEntries = 24;
   localparam logic signed [32:0] GainQ30 = 33'sd652032874;
   localparam logic signed [32:0] OneQ30 = 33'sd1073741824;
   localparam logic signed [31:0] OneQ16 = 32'sd65536;
   localparam logic [3:0] LastIndex = 4'd15;

   // cosine and sine of one angle, Q2.30
   typedef struct packed {
      logic signed [31:0] cos_v;
      logic signed [31:0] sin_v;
   } cs_type;

   // upper 3x3 rotation part, column-major, Q2.30 with one guard bit
   typedef logic signed [8:0][32:0] rot_type;

   // side payload that travels alongside the rotation pipeline
   typedef struct packed {
      logic signed [31:0] shift_x;
      logic signed [31:0] shift_y;
      logic signed [31:0] shift_z;
      logic signed [31:0] factor_x;
      logic signed [31:0] factor_y;
      logic signed [31:0] factor_z;
   } side_type;

   // arctangent of 2^-i in units of 2^-32 turn
   function automatic logic signed [32:0] atan_turn(input int unsigned idx);
      logic signed [32:0] val;
      unique case (idx)
         0:  val = 33'sd536870912;
         1:  val = 33'sd316933406;
         2:  val = 33'sd167458907;
         3:  val = 33'sd85004756;
         4:  val = 33'sd42667331;
         5:  val = 33'sd21354465;
         6:  val = 33'sd10679838;
         7:  val = 33'sd5340245;
         8:  val = 33'sd2670163;
         9:  val = 33'sd1335087;
         10: val = 33'sd667544;
         11: val = 33'sd333772;
         12: val = 33'sd166886;
         13: val = 33'sd83443;
         14: val = 33'sd41722;
         15: val = 33'sd20861;
         16: val = 33'sd10430;
         17: val = 33'sd5215;
         18: val = 33'sd2608;
         19: val = 33'sd1304;
         20: val = 33'sd652;
         21: val = 33'sd326;
         22: val = 33'sd163;
         23: val = 33'sd81;
         default: val = 33'sd0;
      endcase
      return val;
   endfunction

   // Q2.30 product, round half up
   function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b + 64'sd536870912;
      return p[61:30];
   endfunction

endpackage

// ===== src/trs_cordic.sv =====
// One CORDIC lane: fully pipelined sine/cosine of a 16-bit turn fraction.
// Depends on trs_pkg.
module trs_cordic #(
   parameter int unsigned STEPS = 16
) (
   input  logic           clock,
   input  logic [15:0]    angle,
   output trs_pkg::cs_type cs
);
   import trs_pkg::*;

   logic signed [32:0] x_ff [0:STEPS];
   logic signed [32:0] y_ff [0:STEPS];
   logic signed [32:0] z_ff [0:STEPS];
   logic [1:0]         q_ff [0:STEPS];
   cs_type             cs_ff;
   logic signed [32:0] c_raw, s_raw;

   // load the residual angle and quadrant
   always_ff @(posedge clock) begin
      x_ff[0] <= GainQ30;
      y_ff[0] <= '0;
      z_ff[0] <= $signed({3'b000, angle[13:0], 16'h0000});
      q_ff[0] <= angle[15:14];
   end

   // one micro-rotation per stage
   for (genvar i = 0; i < STEPS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (z_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - atan_turn(i);
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + atan_turn(i);
         end
         q_ff[i+1] <= q_ff[i];
      end
   end

   // fold in the quadrant
   always_comb begin
      unique case (q_ff[STEPS])
         2'd0: begin c_raw = x_ff[STEPS];  s_raw = y_ff[STEPS];  end
         2'd1: begin c_raw = -y_ff[STEPS]; s_raw = x_ff[STEPS];  end
         2'd2: begin c_raw = -x_ff[STEPS]; s_raw = -y_ff[STEPS]; end
         default: begin c_raw = y_ff[STEPS]; s_raw = -x_ff[STEPS]; end
      endcase
   end

   // clamp to the unit range and register
   always_ff @(posedge clock) begin
      cs_ff.cos_v <= (c_raw > OneQ30) ? OneQ30[31:0] :
                     (c_raw < -OneQ30) ? -OneQ30[31:0] : c_raw[31:0];
      cs_ff.sin_v <= (s_raw > OneQ30) ? OneQ30[31:0] :
                     (s_raw < -OneQ30) ? -OneQ30[31:0] : s_raw[31:0];
   end

   assign cs = cs_ff;

endmodule

// ===== src/trs_rot.sv =====
// Merge stage: combines the three lanes' sine/cosine into the rotation
// matrix Rz*Ry*Rx over two registered product stages. Depends on trs_pkg.
module trs_rot (
   input  logic             clock,
   input  trs_pkg::cs_type  cs_x,
   input  trs_pkg::cs_type  cs_y,
   input  trs_pkg::cs_type  cs_z,
   output trs_pkg::rot_type rot
);
   import trs_pkg::*;

   logic signed [31:0] czsy_ff, szsy_ff, czcy_ff, szcy_ff, szcx_ff, czcx_ff;
   logic signed [31:0] cysx_ff, szsx_ff, czsx_ff, cycx_ff, sy_ff, cx_ff, sx_ff;
   rot_type            rot_ff;

   // two-factor products
   always_ff @(posedge clock) begin
      czsy_ff <= mul_q30(cs_z.cos_v, cs_y.sin_v);
      szsy_ff <= mul_q30(cs_z.sin_v, cs_y.sin_v);
      czcy_ff <= mul_q30(cs_z.cos_v, cs_y.cos_v);
      szcy_ff <= mul_q30(cs_z.sin_v, cs_y.cos_v);
      szcx_ff <= mul_q30(cs_z.sin_v, cs_x.cos_v);
      czcx_ff <= mul_q30(cs_z.cos_v, cs_x.cos_v);
      cysx_ff <= mul_q30(cs_y.cos_v, cs_x.sin_v);
      szsx_ff <= mul_q30(cs_z.sin_v, cs_x.sin_v);
      czsx_ff <= mul_q30(cs_z.cos_v, cs_x.sin_v);
      cycx_ff <= mul_q30(cs_y.cos_v, cs_x.cos_v);
      sy_ff   <= cs_y.sin_v;
      cx_ff   <= cs_x.cos_v;
      sx_ff   <= cs_x.sin_v;
   end

   // three-factor products and the sums
   always_ff @(posedge clock) begin
      rot_ff[0] <= 33'(czcy_ff);
      rot_ff[1] <= 33'(szcy_ff);
      rot_ff[2] <= -33'(sy_ff);
      rot_ff[3] <= 33'(mul_q30(czsy_ff, sx_ff)) - 33'(szcx_ff);
      rot_ff[4] <= 33'(mul_q30(szsy_ff, sx_ff)) + 33'(czcx_ff);
      rot_ff[5] <= 33'(cysx_ff);
      rot_ff[6] <= 33'(mul_q30(czsy_ff, cx_ff)) + 33'(szsx_ff);
      rot_ff[7] <= 33'(mul_q30(szsy_ff, cx_ff)) - 33'(czsx_ff);
      rot_ff[8] <= 33'(cycx_ff);
   end

   assign rot = rot_ff;

endmodule

// ===== src/trs_emit.sv =====
// Output serialiser: scales one rotation entry per cycle and streams the
// sixteen matrix elements in column-major order. Depends on trs_pkg.
module trs_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  trs_pkg::rot_type   rot,
   input  trs_pkg::side_type  side,
   output logic               rsp_valid,
   output logic [3:0]         rsp_element_index,
   output logic signed [31:0] rsp_element_value,
   output logic               rsp_last_element
);
   import trs_pkg::*;

   rot_type            rot_ff;
   side_type           side_ff;
   logic               act_ff;
   logic [3:0]         cnt_ff;
   logic               valid_ff;
   logic [3:0]         index_ff;
   logic signed [31:0] value_ff;
   logic signed [32:0] r_sel;
   logic signed [31:0] f_sel;
   logic signed [64:0] prod;
   logic signed [34:0] scaled;
   logic signed [31:0] value_in;

   // hold the item and count through its elements
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (load) begin
         act_ff <= 1'b1;
         cnt_ff <= '0;
      end else if (act_ff) begin
         act_ff <= (cnt_ff != LastIndex);
         cnt_ff <= cnt_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rot_ff  <= rot;
         side_ff <= side;
      end
   end

   // select and scale the current element
   always_comb begin
      r_sel = rot_ff[4'(cnt_ff[3:2] * 2'd3 + 4'(cnt_ff[1:0]))];
      unique case (cnt_ff[3:2])
         2'd0:    f_sel = side_ff.factor_x;
         2'd1:    f_sel = side_ff.factor_y;
         default: f_sel = side_ff.factor_z;
      endcase
      prod   = r_sel * f_sel + 65'sd536870912;
      scaled = prod[64:30];
      priority if (cnt_ff == LastIndex)  value_in = OneQ16;
      else if (cnt_ff[1:0] == 2'd3)      value_in = '0;
      else if (cnt_ff[3:2] == 2'd3) begin
         unique case (cnt_ff[1:0])
            2'd0:    value_in = side_ff.shift_x;
            2'd1:    value_in = side_ff.shift_y;
            default: value_in = side_ff.shift_z;
         endcase
      end
      else if (scaled > 35'sd2147483647)  value_in = 32'sh7fffffff;
      else if (scaled < -35'sd2147483648) value_in = 32'sh80000000;
      else                                value_in = scaled[31:0];
   end

   // register the result
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= act_ff;
      index_ff <= cnt_ff;
      value_ff <= value_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_element_index = index_ff;
   assign rsp_element_value = value_ff;
   assign rsp_last_element  = valid_ff && (index_ff == LastIndex);

endmodule

// ===== src/trs_model_matrix_builder.sv =====
// TRS model matrix builder top level: three CORDIC lanes, rotation merge
// stage and output serialiser. Depends on trs_pkg and the trs_* modules.
//
// Usage: present the translation, Euler angles and scale factors on the
// req_ ports and raise start; the item is taken at the edge where start is
// high and busy is low. Busy stays high after each item so that items are
// spaced by the sixteen elements that the single result port carries per item.
// Results: sixteen consecutive elements with rsp_valid high, 0 to 15 in
// column-major order, rsp_last_element on element 15. The first element
// passes the CORDIC pipeline, the two product stages, the serialiser and
// the output register before it appears. A new item flows through the
// lanes while the previous matrix is still being streamed.
// The receiver cannot stall: each result is shown for one cycle only.
// Reset clears busy, the valid line and the serialiser; no item in flight
// survives it.
module trs_model_matrix_builder #(
   parameter int unsigned CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_shift_x,
   input  logic signed [31:0] req_shift_y,
   input  logic signed [31:0] req_shift_z,
   input  logic [15:0]        req_angle_x,
   input  logic [15:0]        req_angle_y,
   input  logic [15:0]        req_angle_z,
   input  logic signed [31:0] req_factor_x,
   input  logic signed [31:0] req_factor_y,
   input  logic signed [31:0] req_factor_z,
   output logic               rsp_valid,
   output logic [3:0]         rsp_element_index,
   output logic signed [31:0] rsp_element_value,
   output logic               rsp_last_element
);
   import trs_pkg::*;

   // length of the valid line, whose last stage loads the rotation matrix
   // and the side payload into the serialiser
   localparam int unsigned Lat = CORDIC_STEPS + 4;

   logic     accept;
   logic [3:0] gap_ff;
   logic     v_ff [0:Lat-1];
   side_type side_ff [0:Lat-1];
   cs_type   cs_x, cs_y, cs_z;
   rot_type  rot;

   assign accept = start && !busy;
   assign busy   = (gap_ff != 4'd0);

   // space items so that their element streams do not overlap
   always_ff @(posedge clock) begin
      if (reset)               gap_ff <= '0;
      else if (accept)         gap_ff <= LastIndex;
      else if (gap_ff != 4'd0) gap_ff <= gap_ff - 4'd1;
   end

   // carry the valid mark and side payload alongside the lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < Lat; k++) v_ff[k] <= 1'b0;
      end else begin
         v_ff[0] <= accept;
         for (int k = 1; k < Lat; k++) v_ff[k] <= v_ff[k-1];
      end
      side_ff[0] <= '{shift_x: req_shift_x, shift_y: req_shift_y,
                      shift_z: req_shift_z, factor_x: req_factor_x,
                      factor_y: req_factor_y, factor_z: req_factor_z};
      for (int k = 1; k < Lat; k++) side_ff[k] <= side_ff[k-1];
   end

   trs_cordic #(.STEPS(CORDIC_STEPS)) u_lane_x (
      .clock(clock), .angle(req_angle_x), .cs(cs_x));
   trs_cordic #(.STEPS(CORDIC_STEPS)) u_lane_y (
      .clock(clock), .angle(req_angle_y), .cs(cs_y));
   trs_cordic #(.STEPS(CORDIC_STEPS)) u_lane_z (
      .clock(clock), .angle(req_angle_z), .cs(cs_z));

   trs_rot u_rot (
      .clock(clock), .cs_x(cs_x), .cs_y(cs_y), .cs_z(cs_z), .rot(rot));

   trs_emit u_emit (
      .clock             (clock),
      .reset             (reset),
      .load              (v_ff[Lat-1]),
      .rot               (rot),
      .side              (side_ff[Lat-1]),
      .rsp_valid         (rsp_valid),
      .rsp_element_index (rsp_element_index),
      .rsp_element_value (rsp_element_value),
      .rsp_last_element  (rsp_last_element)
   );

endmodule

// ===== src/trs_checker.sv =====
// Port-level checker for the TRS model matrix builder and its bind.
// Depends on the top level's ports only.
module trs_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [3:0]  rsp_element_index,
   input logic [31:0] rsp_element_value,
   input logic        rsp_last_element
);

   // an accepted item blocks the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised after item");

   // elements run consecutively within a matrix
   a_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_element |=>
         rsp_valid && rsp_element_index == $past(rsp_element_index) + 4'd1)
      else $error("element stream broken");

   // last flag only on element fifteen
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_element == (rsp_element_index == 4'd15)))
      else $error("last flag misplaced");

   // homogeneous corner is one
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_element |-> rsp_element_value == 32'h00010000)
      else $error("corner element not one");

endmodule

bind trs_model_matrix_builder trs_checker u_trs_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_element_index(rsp_element_index),
   .rsp_element_value(rsp_element_value), .rsp_last_element(rsp_last_element)
);

// ===== sim/trs_matrix_checker.sv =====
// Checker for the TRS model matrix builder: watches the item and element
// channels, predicts the 16 matrix elements per item and compares them.
// Depends on trs_pkg only for the Q16.16 unit constant.
`timescale 1ns / 100ps

module trs_matrix_checker #(
   parameter int unsigned CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [31:0] req_shift_x,
   input  logic signed [31:0] req_shift_y,
   input  logic signed [31:0] req_shift_z,
   input  logic [15:0]        req_angle_x,
   input  logic [15:0]        req_angle_y,
   input  logic [15:0]        req_angle_z,
   input  logic signed [31:0] req_factor_x,
   input  logic signed [31:0] req_factor_y,
   input  logic signed [31:0] req_factor_z,
   input  logic               rsp_valid,
   input  logic [3:0]         rsp_element_index,
   input  logic signed [31:0] rsp_element_value,
   input  logic               rsp_last_element,
   output int                 fail_count,
   output int                 pending_count
);
   import trs_pkg::*;

   typedef struct {
      logic [3:0]         index;
      logic signed [31:0] value;
      logic               last;
   } element_type;

   element_type pending_elements[$];

   // arctangent per step, units of 2^-32 turn
   localparam longint ArcTable[24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};

   function automatic longint clamp_unit(input longint v);
      if (v > 64'sd1073741824) return 64'sd1073741824;
      if (v < -64'sd1073741824) return -64'sd1073741824;
      return v;
   endfunction

   // rotate the gain vector by the residual angle, then fold in the quadrant
   task automatic angle_sin_cos(input logic [15:0] angle, output longint c,
                                output longint s);
      longint x, y, z, dx, dy;
      x = 652032874;
      y = 0;
      z = longint'(angle[13:0]) <<< 16;
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ArcTable[i];
         end else begin
            x += dx; y -= dy; z += ArcTable[i];
         end
      end
      case (angle[15:14])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
      c = clamp_unit(c);
      s = clamp_unit(s);
   endtask

   function automatic longint round_q30(input longint a, input longint b);
      return (a * b + 64'sd536870912) >>> 30;
   endfunction

   function automatic logic signed [31:0] scaled(input longint r, input longint f);
      longint v;
      v = (r * f + 64'sd536870912) >>> 30;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   // build the model matrix for one item and queue its elements
   task automatic queue_matrix();
      longint cx, sx, cy, sy, cz, sz, czsy, szsy, fx, fy, fz;
      logic signed [31:0] m[16];
      element_type e;
      angle_sin_cos(req_angle_x, cx, sx);
      angle_sin_cos(req_angle_y, cy, sy);
      angle_sin_cos(req_angle_z, cz, sz);
      fx = req_factor_x;
      fy = req_factor_y;
      fz = req_factor_z;
      czsy = round_q30(cz, sy);
      szsy = round_q30(sz, sy);
      m[0]  = scaled(round_q30(cz, cy), fx);
      m[1]  = scaled(round_q30(sz, cy), fx);
      m[2]  = scaled(-sy, fx);
      m[3]  = '0;
      m[4]  = scaled(round_q30(czsy, sx) - round_q30(sz, cx), fy);
      m[5]  = scaled(round_q30(szsy, sx) + round_q30(cz, cx), fy);
      m[6]  = scaled(round_q30(cy, sx), fy);
      m[7]  = '0;
      m[8]  = scaled(round_q30(czsy, cx) + round_q30(sz, sx), fz);
      m[9]  = scaled(round_q30(szsy, cx) - round_q30(cz, sx), fz);
      m[10] = scaled(round_q30(cy, cx), fz);
      m[11] = '0;
      m[12] = req_shift_x;
      m[13] = req_shift_y;
      m[14] = req_shift_z;
      m[15] = OneQ16;
      for (int k = 0; k < 16; k++) begin
         e.index = k[3:0];
         e.value = m[k];
         e.last  = (k == 15);
         pending_elements.push_back(e);
      end
   endtask

   // sample both channels at the edge
   always @(posedge clock) begin
      element_type e;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_elements.size() == 0) begin
               $display("%0t: unexpected element idx %0d value %0d", $time,
                        rsp_element_index, rsp_element_value);
               fail_count++;
            end else begin
               e = pending_elements.pop_front();
               if (e.index !== rsp_element_index || e.value !== rsp_element_value ||
                   e.last !== rsp_last_element) begin
                  $display("%0t: element mismatch expected idx %0d val %0d last %0b,",
                           $time, e.index, e.value, e.last);
                  $display("   actual idx %0d val %0d last %0b", rsp_element_index,
                           rsp_element_value, rsp_last_element);
                  fail_count++;
               end
            end
         end
         if (start && !busy) queue_matrix();
      end
      pending_count = pending_elements.size();
   end
endmodule

// ===== sim/tb_trs_model_matrix_builder.sv =====
// Testbench top for the TRS model matrix builder: drives directed and random
// items with random gaps and gives the verdict. Depends on trs_matrix_checker.
`timescale 1ns / 100ps

module tb_trs_model_matrix_builder;
   localparam int unsigned Steps = 16;
   localparam int CycleLimit = 400000;

   logic clock, reset, start, busy;
   logic signed [31:0] shift_x, shift_y, shift_z, factor_x, factor_y, factor_z;
   logic [15:0] angle_x, angle_y, angle_z;
   logic rsp_valid, rsp_last_element;
   logic [3:0] rsp_element_index;
   logic signed [31:0] rsp_element_value;
   int fail_count, pending_count;
   int cycle_count = 0;

   trs_model_matrix_builder #(.CORDIC_STEPS(Steps)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_shift_x(shift_x), .req_shift_y(shift_y), .req_shift_z(shift_z),
      .req_angle_x(angle_x), .req_angle_y(angle_y), .req_angle_z(angle_z),
      .req_factor_x(factor_x), .req_factor_y(factor_y), .req_factor_z(factor_z),
      .rsp_valid(rsp_valid), .rsp_element_index(rsp_element_index),
      .rsp_element_value(rsp_element_value), .rsp_last_element(rsp_last_element));

   trs_matrix_checker #(.CORDIC_STEPS(Steps)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_shift_x(shift_x), .req_shift_y(shift_y), .req_shift_z(shift_z),
      .req_angle_x(angle_x), .req_angle_y(angle_y), .req_angle_z(angle_z),
      .req_factor_x(factor_x), .req_factor_y(factor_y), .req_factor_z(factor_z),
      .rsp_valid(rsp_valid), .rsp_element_index(rsp_element_index),
      .rsp_element_value(rsp_element_value), .rsp_last_element(rsp_last_element),
      .fail_count(fail_count), .pending_count(pending_count));

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0001_0000;
         3: return 32'hFFFF_0000;
         4: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
         5: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick_angle();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 3)) << 14;
         1: return (16'($urandom_range(0, 3)) << 14) + 16'($urandom_range(0, 3)) - 16'd1;
         default: return 16'($urandom);
      endcase
   endfunction

   // present one item and hold it until taken, then an optional gap
   task automatic send_item(input logic [31:0] sx, sy, sz, input logic [15:0] ax, ay,
                            az, input logic [31:0] fx, fy, fz, input bit gaps);
      int gap;
      start <= 1'b1;
      shift_x <= sx; shift_y <= sy; shift_z <= sz;
      angle_x <= ax; angle_y <= ay; angle_z <= az;
      factor_x <= fx; factor_y <= fy; factor_z <= fz;
      @(posedge clock);
      while (busy) @(posedge clock);
      gap = 0;
      if (gaps) gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                   : $urandom_range(0, 3);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      int wait_cycles;
      reset = 1'b1;
      start = 1'b0;
      shift_x = '0; shift_y = '0; shift_z = '0;
      angle_x = '0; angle_y = '0; angle_z = '0;
      factor_x = '0; factor_y = '0; factor_z = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: identity, quadrant edges, extreme shifts and scales
      send_item(0, 0, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
      send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'h4000, 16'h8000,
                16'hC000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
      send_item(32'h8000_0000, 32'h7FFF_FFFF, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 1'b1);
      send_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 16'h3FFF, 16'h4001,
                16'h7FFF, 32'h0002_0000, 32'hFFFE_0000, 0, 1'b1);
      send_item(32'hAAAA_AAAA, 32'h5555_5555, 32'hEDCB_A987, 16'h2000, 16'hA000,
                16'hE000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      for (int q = 0; q < 16; q++)
         send_item(q, -q, q << 16, 16'(q) << 12, 16'(15 - q) << 12, 16'h5555 ^ 16'(q),
                   32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, q[0]);

      // random items, with stretches of back-to-back traffic
      for (int n = 0; n < 480; n++)
         send_item(pick_word(), pick_word(), pick_word(), pick_angle(), pick_angle(),
                   pick_angle(), pick_word(), pick_word(), pick_word(),
                   (n / 40) % 3 != 1);
      start <= 1'b0;

      // drain, then allow the pipeline latency to settle
      wait_cycles = 0;
      while (pending_count != 0 && wait_cycles < 2000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (Steps + 40) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

// ===== files.f =====
src/trs_pkg.sv
src/trs_cordic.sv
src/trs_rot.sv
src/trs_emit.sv
src/trs_model_matrix_builder.sv
src/trs_checker.sv
sim/trs_matrix_checker.sv
sim/tb_trs_model_matrix_builder.sv
